// File: rtl/tcw_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the text console writer.
// Used by the address unit and the top level of the block.
package tcw_pkg;

  // Default screen geometry.
  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  // Cell contents and cursor rules.
  localparam logic [7:0] BLANK_CHAR  = 8'h20;
  localparam logic [7:0] RESET_ATTR  = 8'h07;
  localparam int         TAB_STOP    = 8;

  // Control characters handled by put-char mode.
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_EN = 1'd1;
  localparam int CFG_DATA_W = 8;

  // Item modes.
  typedef enum logic [1:0] {
    MODE_PUT   = 2'd0,
    MODE_RAW   = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_MEM,
    S_SCROLL,
    S_BLANK,
    S_FILL,
    S_POS
  } state_t;

endpackage

// File: rtl/tcw_in_if.sv
`timescale 1ns / 1ps
// Input channel of the text console writer: valid/ready and one item.
// Field widths are fixed; no package dependency.
interface tcw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_byte;
  logic [4:0] cell_row;
  logic [6:0] cell_col;
  logic [7:0] cell_attr;

  modport source (output valid, mode, char_byte, cell_row, cell_col, cell_attr,
                  input ready);
  modport sink   (input valid, mode, char_byte, cell_row, cell_col, cell_attr,
                  output ready);
endinterface

// File: rtl/tcw_out_if.sv
`timescale 1ns / 1ps
// Result channel of the text console writer: valid/ready and one item.
// Field widths are fixed; no package dependency.
interface tcw_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] cursor_pos;
  logic        mirror_valid;
  logic [7:0]  mirror_byte;
  logic [15:0] cell_data;
  logic        scrolled;

  modport source (output valid, cursor_pos, mirror_valid, mirror_byte, cell_data,
                  scrolled, input ready);
  modport sink   (input valid, cursor_pos, mirror_valid, mirror_byte, cell_data,
                  scrolled, output ready);
endinterface

// File: rtl/tcw_addr_unit.sv
`timescale 1ns / 1ps
// Shared address unit: turns a row and column into a linear cell index.
// Used by the sequencer for cell addresses and for the cursor position.
module tcw_addr_unit #(
  parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF,
  localparam int RW = $clog2(SCREEN_ROWS),
  localparam int CW = $clog2(SCREEN_COLS),
  localparam int AW = $clog2(SCREEN_ROWS * SCREEN_COLS)
) (
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr
);

  // One small constant multiply and an add; the caller registers the result.
  assign addr = AW'(AW'(row) * AW'(SCREEN_COLS)) + AW'(col);

endmodule

// File: rtl/tcw_screen_mem.sv
`timescale 1ns / 1ps
// Screen cell store: one write port and one read port with registered data.
// No package dependency.
module tcw_screen_mem #(
  parameter int DEPTH = 2000,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [15:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [15:0]   rdata
);

  logic [15:0] cells [DEPTH];
  logic [15:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  // Read port; data is held until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= cells[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/text_console_writer.sv
`timescale 1ns / 1ps
// Text console writer top level: sequencer, cursor and configuration.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_addr_unit and tcw_screen_mem.
//
// Usage: items arrive on in_ch (valid/ready). Mode 0 puts a character at the
// cursor, mode 1 writes a raw cell, mode 2 clears the screen and mode 3 reads
// a cell. Every item gives exactly one result item on out_ch (valid/ready),
// carrying the cursor position, the serial mirror byte, read data and a
// scroll flag. Configuration registers (text attribute, mirror enable) are
// written through cfg_we / cfg_index / cfg_wdata; the user must write them
// only while the block is idle, which the block itself does not enforce.
// Timing: the block handles one item at a time. A put char, raw write or
// read steps through address, memory access and cursor position from
// acceptance to a valid result; the next item is accepted once idle again.
// A put that scrolls also copies each cell one row up, then blanks the
// bottom row, bound by the single port pair copying one cell per cycle.
// A clear writes one blank cell per cycle. Reset: after rst_n rises all
// cells are swept to blanks (attribute 7) one per cycle; no item is taken.
// Stall: a result waits in the output register; the block finishes the next
// item up to its result and then holds until the receiver takes the first.
module text_console_writer #(
  parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  tcw_in_if.sink                         in_ch,
  tcw_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int RW    = $clog2(SCREEN_ROWS);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);

  localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLS);
  localparam logic [AW-1:0] LAST_ROW0 = AW'(CELLS - SCREEN_COLS);
  localparam logic [RW-1:0] ROW_MAX   = RW'(SCREEN_ROWS - 1);
  localparam logic [CW-1:0] COL_MAX   = CW'(SCREEN_COLS - 1);

  // Control state.
  tcw_pkg::state_t state_r, state_nxt;
  logic            boot_r, boot_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   wr_addr_r, wr_addr_nxt;
  logic            scr_r, scr_nxt;
  logic [RW-1:0]   cur_row_r, cur_row_nxt;
  logic [CW-1:0]   cur_col_r, cur_col_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [7:0]      text_attr_r;
  logic            mirror_en_r;

  // Item and work registers.
  tcw_pkg::mode_t  mode_r;
  logic [7:0]      ch_r;
  logic [4:0]      crow_r;
  logic [6:0]      ccol_r;
  logic [7:0]      cattr_r;
  logic [AW-1:0]   addr_r, addr_nxt;
  logic [15:0]     wdata_r, wdata_nxt;
  logic            dowr_r, dowr_nxt;

  // Result registers.
  logic [10:0]     o_pos_r;
  logic            o_mval_r;
  logic [7:0]      o_mbyte_r;
  logic [15:0]     o_cell_r;
  logic            o_scr_r;
  logic            out_load;

  // Shared address unit and memory ports.
  logic [RW-1:0]   mul_row;
  logic [CW-1:0]   mul_col;
  logic [AW-1:0]   mul_addr;
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [15:0]     mem_wdata, mem_rdata;

  // Put-char helpers.
  logic            in_screen;
  logic [15:0]     blank;
  logic [CW:0]     col_p1, tab_col;
  logic [RW:0]     row_p1;
  logic [RW-1:0]   wr_row;
  logic [CW-1:0]   wr_col;
  logic            adv_row;

  assign in_screen = (32'(crow_r) < 32'(SCREEN_ROWS)) && (32'(ccol_r) < 32'(SCREEN_COLS));
  assign blank     = {text_attr_r, tcw_pkg::BLANK_CHAR};
  assign col_p1    = {1'b0, cur_col_r} + (CW+1)'(1);
  assign tab_col   = ({1'b0, cur_col_r} + (CW+1)'(tcw_pkg::TAB_STOP))
                     & ~(CW+1)'(tcw_pkg::TAB_STOP - 1);
  assign row_p1    = {1'b0, cur_row_r} + (RW+1)'(1);

  tcw_addr_unit #(
    .SCREEN_COLS(SCREEN_COLS),
    .SCREEN_ROWS(SCREEN_ROWS)
  ) u_addr (
    .row (mul_row),
    .col (mul_col),
    .addr(mul_addr)
  );

  tcw_screen_mem #(
    .DEPTH(CELLS)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign in_ch.ready = (state_r == tcw_pkg::S_IDLE);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_attr_r <= tcw_pkg::RESET_ATTR;
      mirror_en_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tcw_pkg::CFG_TEXT_ATTR: text_attr_r <= cfg_wdata;
        tcw_pkg::CFG_MIRROR_EN: mirror_en_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      mode_r  <= tcw_pkg::mode_t'(in_ch.mode);
      ch_r    <= in_ch.char_byte;
      crow_r  <= in_ch.cell_row;
      ccol_r  <= in_ch.cell_col;
      cattr_r <= in_ch.cell_attr;
    end
  end

  // Sequencer state and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::S_FILL;
      boot_r      <= 1'b1;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      scr_r       <= 1'b0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      out_valid_r <= 1'b0;
      dowr_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      boot_r      <= boot_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      scr_r       <= scr_nxt;
      cur_row_r   <= cur_row_nxt;
      cur_col_r   <= cur_col_nxt;
      out_valid_r <= out_valid_nxt;
      dowr_r      <= dowr_nxt;
    end
  end

  // Work registers.
  always_ff @(posedge clk) begin
    addr_r    <= addr_nxt;
    wdata_r   <= wdata_nxt;
    wr_addr_r <= wr_addr_nxt;
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      o_pos_r   <= 11'(mul_addr);
      o_mval_r  <= (mode_r == tcw_pkg::MODE_PUT) && mirror_en_r;
      o_mbyte_r <= ((mode_r == tcw_pkg::MODE_PUT) && mirror_en_r) ? ch_r : 8'h00;
      o_cell_r  <= ((mode_r == tcw_pkg::MODE_READ) && in_screen) ? mem_rdata : 16'h0000;
      o_scr_r   <= scr_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.cursor_pos   = o_pos_r;
  assign out_ch.mirror_valid = o_mval_r;
  assign out_ch.mirror_byte  = o_mbyte_r;
  assign out_ch.cell_data    = o_cell_r;
  assign out_ch.scrolled     = o_scr_r;

  // Cursor step for each mode: new cursor and the cell to write.
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    wr_row      = cur_row_r;
    wr_col      = cur_col_r;
    adv_row     = 1'b0;
    dowr_nxt    = 1'b0;
    wdata_nxt   = {text_attr_r, ch_r};
    scr_nxt     = scr_r;
    if (state_r == tcw_pkg::S_CALC) begin
      scr_nxt = 1'b0;
      unique case (mode_r)
        tcw_pkg::MODE_PUT: begin
          unique case (ch_r)
            tcw_pkg::CH_LF: begin
              cur_col_nxt = '0;
              adv_row     = 1'b1;
            end
            tcw_pkg::CH_CR: begin
              cur_col_nxt = '0;
            end
            tcw_pkg::CH_BS: begin
              if (cur_col_r != '0) begin
                cur_col_nxt = cur_col_r - CW'(1);
              end else if (cur_row_r != '0) begin
                cur_row_nxt = cur_row_r - RW'(1);
                cur_col_nxt = COL_MAX;
              end
              wr_row    = cur_row_nxt;
              wr_col    = cur_col_nxt;
              dowr_nxt  = 1'b1;
              wdata_nxt = blank;
            end
            tcw_pkg::CH_TAB: begin
              if (tab_col >= (CW+1)'(SCREEN_COLS)) begin
                cur_col_nxt = '0;
                adv_row     = 1'b1;
              end else begin
                cur_col_nxt = tab_col[CW-1:0];
              end
            end
            default: begin
              dowr_nxt = 1'b1;
              if (col_p1 >= (CW+1)'(SCREEN_COLS)) begin
                cur_col_nxt = '0;
                adv_row     = 1'b1;
              end else begin
                cur_col_nxt = col_p1[CW-1:0];
              end
            end
          endcase
          // Moving past the last row scrolls and keeps the cursor there.
          if (adv_row) begin
            if (row_p1 == (RW+1)'(SCREEN_ROWS)) begin
              scr_nxt     = 1'b1;
              cur_row_nxt = ROW_MAX;
            end else begin
              cur_row_nxt = row_p1[RW-1:0];
            end
          end
        end
        tcw_pkg::MODE_RAW: begin
          dowr_nxt  = in_screen;
          wdata_nxt = {cattr_r, ch_r};
        end
        tcw_pkg::MODE_CLEAR: begin
          cur_row_nxt = '0;
          cur_col_nxt = '0;
        end
        tcw_pkg::MODE_READ: ;
        default: ;
      endcase
    end else begin
      dowr_nxt  = dowr_r;
      wdata_nxt = wdata_r;
    end
  end

  // Address unit input: cell address while computing, cursor otherwise.
  always_comb begin
    if (state_r == tcw_pkg::S_CALC) begin
      if (mode_r == tcw_pkg::MODE_PUT) begin
        mul_row = wr_row;
        mul_col = wr_col;
      end else begin
        mul_row = RW'(crow_r);
        mul_col = CW'(ccol_r);
      end
    end else begin
      mul_row = cur_row_r;
      mul_col = cur_col_r;
    end
  end

  // Sequencer: next state, memory ports and result handshake.
  always_comb begin
    state_nxt     = state_r;
    boot_nxt      = boot_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    wr_addr_nxt   = wr_addr_r;
    addr_nxt      = addr_r;
    mem_we        = 1'b0;
    mem_waddr     = scan_r;
    mem_wdata     = blank;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      tcw_pkg::S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = tcw_pkg::S_CALC;
        end
      end
      tcw_pkg::S_CALC: begin
        addr_nxt = mul_addr;
        scan_nxt = '0;
        if (mode_r == tcw_pkg::MODE_CLEAR) begin
          state_nxt = tcw_pkg::S_FILL;
        end else begin
          state_nxt = tcw_pkg::S_MEM;
        end
      end
      tcw_pkg::S_MEM: begin
        mem_we    = dowr_r;
        mem_waddr = addr_r;
        mem_wdata = wdata_r;
        mem_re    = (mode_r == tcw_pkg::MODE_READ);
        mem_raddr = addr_r;
        if (scr_r) begin
          scan_nxt  = COLS_A;
          state_nxt = tcw_pkg::S_SCROLL;
        end else begin
          state_nxt = tcw_pkg::S_POS;
        end
      end
      tcw_pkg::S_SCROLL: begin
        // Read one cell a cycle and write it one row up in the following cycle.
        mem_re      = 1'b1;
        mem_raddr   = scan_r;
        mem_we      = pend_r;
        mem_waddr   = wr_addr_r;
        mem_wdata   = mem_rdata;
        pend_nxt    = 1'b1;
        wr_addr_nxt = scan_r - COLS_A;
        if (scan_r == LAST_CELL) begin
          scan_nxt  = LAST_ROW0;
          state_nxt = tcw_pkg::S_BLANK;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      tcw_pkg::S_BLANK: begin
        // Finish the last copy, then blank the bottom row.
        mem_we = 1'b1;
        if (pend_r) begin
          mem_waddr = wr_addr_r;
          mem_wdata = mem_rdata;
          pend_nxt  = 1'b0;
        end else begin
          mem_waddr = scan_r;
          mem_wdata = blank;
          if (scan_r == LAST_CELL) begin
            state_nxt = tcw_pkg::S_POS;
          end else begin
            scan_nxt = scan_r + AW'(1);
          end
        end
      end
      tcw_pkg::S_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = scan_r;
        mem_wdata = boot_r ? {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CHAR} : blank;
        if (scan_r == LAST_CELL) begin
          boot_nxt  = 1'b0;
          state_nxt = boot_r ? tcw_pkg::S_IDLE : tcw_pkg::S_POS;
        end else begin
          scan_nxt = scan_r + AW'(1);
        end
      end
      tcw_pkg::S_POS: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = tcw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tcw_pkg::S_IDLE;
      end
    endcase
  end

  // The cursor never leaves the screen between items.
  a_cursor_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r <= ROW_MAX) && (cur_col_r <= COL_MAX))
    else $error("cursor outside the screen");

  // A result appears only out of the cursor-position step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == tcw_pkg::S_POS))
    else $error("result raised outside the position step");

  // A pending scroll copy exists only while scrolling.
  a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == tcw_pkg::S_SCROLL || state_r == tcw_pkg::S_BLANK))
    else $error("scroll copy pending outside the scroll");

  // The power-up sweep finishes before the first item is taken.
  a_boot_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    boot_r |-> !in_ch.ready)
    else $error("item accepted during the power-up sweep");

  // A scroll happens only for a put character.
  a_scroll_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcw_pkg::S_SCROLL) |-> (mode_r == tcw_pkg::MODE_PUT))
    else $error("scroll outside put-char mode");

endmodule
